FILE: hdl/brs_pkg.sv
// Shared types, constants and defaults for the bilinear RGBA sampler.
package brs_pkg;

	// Fixed field widths of the item, result and configuration transactions.
	localparam int COORD_W   = 16;
	localparam int CHAN_W    = 8;
	localparam int NUM_CHAN  = 4;
	localparam int PIX_W     = CHAN_W * NUM_CHAN;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	// Parameter defaults.
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_FRAC_BITS  = 8;

	// Register reset values and the pixel returned outside the active area.
	localparam logic [CFG_W-1:0] RESET_ACTIVE_WIDTH  = 9'd256;
	localparam logic [CFG_W-1:0] RESET_ACTIVE_HEIGHT = 9'd256;
	localparam logic [PIX_W-1:0] BORDER_PIXEL        = 32'hFF00_0000;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_WIDTH  = 1'b0,
		REG_ACTIVE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [CHAN_W-1:0]  in_chan0;
		logic [CHAN_W-1:0]  in_chan1;
		logic [CHAN_W-1:0]  in_chan2;
		logic [CHAN_W-1:0]  in_chan3;
	} sampler_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_chan0;
		logic [CHAN_W-1:0] out_chan1;
		logic [CHAN_W-1:0] out_chan2;
		logic [CHAN_W-1:0] out_chan3;
	} sampler_out_t;

	// Control from the sequencer to the blend unit.
	typedef struct packed {
		logic clear;
		logic acc_en;
	} blend_ctrl_t;

endpackage

FILE: hdl/brs_ram.sv
// Generic single-port synchronous RAM with a registered read.
module brs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: a write, or a read whose data appears next cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: hdl/brs_blend.sv
// Weighted accumulation of neighbour pixels and final rounding per channel.
module brs_blend #(
	parameter int FRAC_BITS = 8
) (
	input  logic                        clk,
	input  brs_pkg::blend_ctrl_t        ctrl,
	input  logic [2*FRAC_BITS:0]        weight,
	input  logic                        in_area,
	input  logic [brs_pkg::PIX_W-1:0]   pix,
	output brs_pkg::sampler_out_t       result
);
	import brs_pkg::*;

	localparam int ACC_W = 2 * FRAC_BITS + 9;
	localparam int RND_W = ACC_W + 1;
	localparam int SUM_W = RND_W - 2 * FRAC_BITS;

	localparam logic [RND_W-1:0] HALF = RND_W'(1) << (2 * FRAC_BITS - 1);

	logic [PIX_W-1:0]  pix_sel;
	logic [ACC_W-1:0]  acc_q [NUM_CHAN];
	logic [CHAN_W-1:0] chan_out [NUM_CHAN];

	// Neighbours outside the active area take the border colour.
	assign pix_sel = in_area ? pix : BORDER_PIXEL;

	// Accumulate weight times channel for each neighbour.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_CHAN; k++) begin
			if (ctrl.clear) begin
				acc_q[k] <= '0;
			end else if (ctrl.acc_en) begin
				acc_q[k] <= acc_q[k] +
					ACC_W'(weight) * ACC_W'(pix_sel[k*CHAN_W +: CHAN_W]);
			end
		end
	end

	// Round to nearest with ties upward, then saturate.
	always_comb begin
		logic [RND_W-1:0] rnd;
		logic [SUM_W-1:0] sum;
		for (int k = 0; k < NUM_CHAN; k++) begin
			rnd = RND_W'(acc_q[k]) + HALF;
			sum = rnd[RND_W-1:2*FRAC_BITS];
			chan_out[k] = (sum > SUM_W'(255)) ? 8'hFF : sum[CHAN_W-1:0];
		end
	end

	assign result.out_chan0 = chan_out[0];
	assign result.out_chan1 = chan_out[1];
	assign result.out_chan2 = chan_out[2];
	assign result.out_chan3 = chan_out[3];

endmodule

FILE: hdl/bilinear_rgba_sampler.sv
// Top level: frame store, item sequencer and configuration registers.
// A write transaction occupies states ST_BASE then ST_WRITE; start may be taken again in the second.
// A sample transaction passes through ST_BASE (one row multiply), ST_READ (four reads from
// the single-port frame memory) and ST_DRAIN (one last accumulate), then strobes in ST_OUT.
// A new transaction may be accepted in the cycle the result is shown.
// Reset restores both size registers to 256; the frame memory holds nothing defined.
module bilinear_rgba_sampler #(
	parameter int MAX_WIDTH  = brs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = brs_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = brs_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  brs_pkg::sampler_in_t          item,
	output logic                          busy,
	output logic                          result_valid,
	output brs_pkg::sampler_out_t         result,
	input  logic                          cfg_we,
	input  logic [brs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [brs_pkg::CFG_W-1:0]     cfg_data
);
	import brs_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = COORD_W - FRAC_BITS;
	localparam int CMP_W = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
	localparam int BASE_W = IW + CFG_W;
	localparam int SUM_W = BASE_W + 1;
	localparam int WT_W  = 2 * FRAC_BITS + 1;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_BASE  = 6'b000010,
		ST_WRITE = 6'b000100,
		ST_READ  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t               state_q, state_d;
	logic [1:0]           nbr_q;
	cmd_t                 cmd_q;
	logic [IW-1:0]        xi_q, yi_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q;
	logic [PIX_W-1:0]     pix_q;
	logic [BASE_W-1:0]    base_q;
	logic [CFG_W-1:0]     width_q, height_q;
	logic [WT_W-1:0]      wt_s1;
	logic                 in_area_s1;
	logic                 rd_valid_s1;

	logic [CFG_W-1:0]     eff_w, eff_h;
	logic                 accept;
	logic                 dx, dy;
	logic [IW:0]          nx, ny;
	logic                 nbr_in_area, wr_in_area;
	logic [SUM_W-1:0]     row_base, rd_sum, wr_sum;
	logic [FRAC_BITS:0]   wx, wy;
	logic [WT_W-1:0]      wt_full;
	logic                 ram_en, ram_we;
	logic [AW-1:0]        ram_addr;
	logic [PIX_W-1:0]     ram_rdata;
	blend_ctrl_t          ctrl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_ACTIVE_WIDTH;
			height_q <= RESET_ACTIVE_HEIGHT;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ACTIVE_WIDTH:  width_q  <= cfg_data;
				REG_ACTIVE_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	// Sizes clamped to the frame store dimensions.
	assign eff_w = (32'(width_q) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_q;
	assign eff_h = (32'(height_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_q;

	// Handshake.
	assign busy   = !(state_q == ST_IDLE || state_q == ST_WRITE || state_q == ST_OUT);
	assign accept = start && !busy;

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_WRITE, ST_OUT: state_d = start ? ST_BASE : ST_IDLE;
			ST_BASE:  state_d = (cmd_q == CMD_WRITE) ? ST_WRITE : ST_READ;
			ST_READ:  state_d = (nbr_q == 2'd3) ? ST_DRAIN : ST_READ;
			ST_DRAIN: state_d = ST_OUT;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nbr_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == ST_READ);
			if (state_q == ST_READ) begin
				nbr_q <= nbr_q + 2'd1;
			end else begin
				nbr_q <= '0;
			end
		end
	end

	// Transaction capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item.cmd;
			xi_q  <= item.x_coord[COORD_W-1:FRAC_BITS];
			yi_q  <= item.y_coord[COORD_W-1:FRAC_BITS];
			fx_q  <= item.x_coord[FRAC_BITS-1:0];
			fy_q  <= item.y_coord[FRAC_BITS-1:0];
			pix_q <= {item.in_chan3, item.in_chan2, item.in_chan1, item.in_chan0};
		end
	end

	// Row start address of the top row.
	always_ff @(posedge clk) begin
		if (state_q == ST_BASE) begin
			base_q <= BASE_W'(yi_q) * BASE_W'(eff_w);
		end
	end

	// Neighbour coordinates, area test and address for the current read.
	assign dx = nbr_q[0];
	assign dy = nbr_q[1];
	assign nx = {1'b0, xi_q} + (IW + 1)'(dx);
	assign ny = {1'b0, yi_q} + (IW + 1)'(dy);
	assign nbr_in_area = (CMP_W'(nx) < CMP_W'(eff_w)) && (CMP_W'(ny) < CMP_W'(eff_h));
	assign row_base = dy ? SUM_W'(base_q) + SUM_W'(eff_w) : SUM_W'(base_q);
	assign rd_sum   = row_base + SUM_W'(nx);

	// Write address and area test.
	assign wr_in_area = (CMP_W'(xi_q) < CMP_W'(eff_w)) && (CMP_W'(yi_q) < CMP_W'(eff_h));
	assign wr_sum     = SUM_W'(base_q) + SUM_W'(xi_q);

	// Bilinear weight of the current neighbour.
	assign wx      = dx ? {1'b0, fx_q} : ONE - {1'b0, fx_q};
	assign wy      = dy ? {1'b0, fy_q} : ONE - {1'b0, fy_q};
	assign wt_full = WT_W'(wx) * WT_W'(wy);

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			wt_s1      <= wt_full;
			in_area_s1 <= nbr_in_area;
		end
	end

	// Frame store access.
	assign ram_we   = (state_q == ST_WRITE) && wr_in_area;
	assign ram_en   = ram_we || (state_q == ST_READ && nbr_in_area);
	assign ram_addr = (state_q == ST_WRITE) ? AW'(wr_sum) : AW'(rd_sum);

	brs_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (pix_q),
		.rdata (ram_rdata)
	);

	// Blend unit.
	assign ctrl.clear  = (state_q == ST_BASE);
	assign ctrl.acc_en = rd_valid_s1;

	brs_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk     (clk),
		.ctrl    (ctrl),
		.weight  (wt_s1),
		.in_area (in_area_s1),
		.pix     (ram_rdata),
		.result  (result)
	);

	assign result_valid = (state_q == ST_OUT);

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bilinear RGBA sampler: directed and random transactions.
`timescale 1ns / 1ps

module testbench;
	import brs_pkg::*;

	localparam int FRAC        = DEF_FRAC_BITS;
	localparam int MAX_W       = DEF_MAX_WIDTH;
	localparam int MAX_H       = DEF_MAX_HEIGHT;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 12;
	localparam int NUM_PHASES  = 9;
	localparam int PHASE_ITEMS = 25;

	// Shadow of the frame store and queue of interpolated pixels still to arrive.
	class sample_scoreboard;
		bit [PIX_W-1:0] pixels [MAX_W*MAX_H];
		bit written [MAX_W*MAX_H];
		int unsigned width_reg;
		int unsigned height_reg;
		sampler_out_t pending_samples[$];
		int unsigned errors;

		function new();
			width_reg = RESET_ACTIVE_WIDTH;
			height_reg = RESET_ACTIVE_HEIGHT;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, int unsigned value);
			if (idx == REG_ACTIVE_WIDTH) begin
				width_reg = value & 'h1FF;
			end else begin
				height_reg = value & 'h1FF;
			end
		endfunction

		function int unsigned eff_w();
			return (width_reg > MAX_W) ? MAX_W : width_reg;
		endfunction

		function int unsigned eff_h();
			return (height_reg > MAX_H) ? MAX_H : height_reg;
		endfunction

		function bit in_area(int unsigned x, int unsigned y);
			return (x < eff_w()) && (y < eff_h());
		endfunction

		function bit [PIX_W-1:0] fetch(int unsigned x, int unsigned y);
			if (!in_area(x, y)) begin
				return BORDER_PIXEL;
			end
			return pixels[y * eff_w() + x];
		endfunction

		// A neighbour may be read if it lies outside the area or has been written.
		function bit readable(int unsigned x, int unsigned y);
			if (!in_area(x, y)) begin
				return 1'b1;
			end
			return written[y * eff_w() + x];
		endfunction

		function bit can_sample(bit [COORD_W-1:0] xc, bit [COORD_W-1:0] yc);
			int unsigned xi;
			int unsigned yi;
			xi = xc >> FRAC;
			yi = yc >> FRAC;
			return readable(xi, yi) && readable(xi + 1, yi) &&
				readable(xi, yi + 1) && readable(xi + 1, yi + 1);
		endfunction

		// Weighted sum of the four neighbours, rounded once and saturated.
		function sampler_out_t bilinear_mix(bit [COORD_W-1:0] xc, bit [COORD_W-1:0] yc);
			longint unsigned s;
			longint unsigned fx;
			longint unsigned fy;
			longint unsigned w00;
			longint unsigned w10;
			longint unsigned w01;
			longint unsigned w11;
			longint unsigned acc;
			longint unsigned r;
			int unsigned xi;
			int unsigned yi;
			bit [PIX_W-1:0] p00;
			bit [PIX_W-1:0] p10;
			bit [PIX_W-1:0] p01;
			bit [PIX_W-1:0] p11;
			bit [CHAN_W-1:0] ch [NUM_CHAN];
			sampler_out_t res;
			s = 64'd1 << FRAC;
			fx = xc & ((1 << FRAC) - 1);
			fy = yc & ((1 << FRAC) - 1);
			xi = xc >> FRAC;
			yi = yc >> FRAC;
			w00 = (s - fx) * (s - fy);
			w10 = fx * (s - fy);
			w01 = (s - fx) * fy;
			w11 = fx * fy;
			p00 = fetch(xi, yi);
			p10 = fetch(xi + 1, yi);
			p01 = fetch(xi, yi + 1);
			p11 = fetch(xi + 1, yi + 1);
			for (int k = 0; k < NUM_CHAN; k++) begin
				acc = w00 * p00[8*k +: 8] + w10 * p10[8*k +: 8] +
					w01 * p01[8*k +: 8] + w11 * p11[8*k +: 8];
				r = (acc + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
				ch[k] = (r > 255) ? 8'd255 : r[7:0];
			end
			res.out_chan0 = ch[0];
			res.out_chan1 = ch[1];
			res.out_chan2 = ch[2];
			res.out_chan3 = ch[3];
			return res;
		endfunction

		// Called for every accepted input transaction, in order of acceptance.
		function void note_item(sampler_in_t it);
			int unsigned xi;
			int unsigned yi;
			xi = it.x_coord >> FRAC;
			yi = it.y_coord >> FRAC;
			if (it.cmd == CMD_WRITE) begin
				if (in_area(xi, yi)) begin
					pixels[yi * eff_w() + xi] =
						{it.in_chan3, it.in_chan2, it.in_chan1, it.in_chan0};
					written[yi * eff_w() + xi] = 1'b1;
				end
			end else begin
				pending_samples.push_back(bilinear_mix(it.x_coord, it.y_coord));
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_sample(sampler_out_t got);
			sampler_out_t want;
			if (pending_samples.size() == 0) begin
				report($sformatf("unexpected result %h", got));
			end else begin
				want = pending_samples.pop_front();
				if (got.out_chan0 !== want.out_chan0)
					report($sformatf("out_chan0 %h, expected %h", got.out_chan0, want.out_chan0));
				if (got.out_chan1 !== want.out_chan1)
					report($sformatf("out_chan1 %h, expected %h", got.out_chan1, want.out_chan1));
				if (got.out_chan2 !== want.out_chan2)
					report($sformatf("out_chan2 %h, expected %h", got.out_chan2, want.out_chan2));
				if (got.out_chan3 !== want.out_chan3)
					report($sformatf("out_chan3 %h, expected %h", got.out_chan3, want.out_chan3));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	sampler_in_t item;
	logic busy;
	logic result_valid;
	sampler_out_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sample_scoreboard sb;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;

	bilinear_rgba_sampler uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Every strobed result is checked against the oldest pending sample.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			sb.check_sample(result);
		end
	end

	function automatic sampler_in_t make_item(cmd_t c, bit [COORD_W-1:0] xc,
			bit [COORD_W-1:0] yc, bit [PIX_W-1:0] px);
		sampler_in_t it;
		it.cmd = c;
		it.x_coord = xc;
		it.y_coord = yc;
		it.in_chan0 = px[7:0];
		it.in_chan1 = px[15:8];
		it.in_chan2 = px[23:16];
		it.in_chan3 = px[31:24];
		return it;
	endfunction

	// Fractions lean towards zero, one half and the largest value.
	function automatic bit [7:0] pick_frac();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic bit [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Offers one transaction after a random gap and waits until it is taken.
	task automatic send_item(sampler_in_t it);
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(5, 30);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 19);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic write_px(bit [7:0] x, bit [7:0] y, bit [PIX_W-1:0] px);
		send_item(make_item(CMD_WRITE, {x, 8'($urandom)}, {y, 8'($urandom)}, px));
	endtask

	task automatic sample_at(bit [COORD_W-1:0] xc, bit [COORD_W-1:0] yc);
		send_item(make_item(CMD_SAMPLE, xc, yc, $urandom));
	endtask

	// Waits until every expected result has arrived and the block is quiet.
	task automatic settle();
		start <= 1'b0;
		while (sb.pending_samples.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACTIVE_WIDTH;
		cfg_data <= w[CFG_W-1:0];
		@(posedge clk);
		sb.set_reg(REG_ACTIVE_WIDTH, w);
		cfg_index <= REG_ACTIVE_HEIGHT;
		cfg_data <= h[CFG_W-1:0];
		@(posedge clk);
		sb.set_reg(REG_ACTIVE_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// One size setting: fill a window of pixels, then mix writes and samples around it.
	task automatic run_phase(int unsigned w, int unsigned h, int unsigned n_items);
		int unsigned ew;
		int unsigned eh;
		int unsigned ww;
		int unsigned wh;
		int unsigned ox;
		int unsigned oy;
		int unsigned xi;
		int unsigned yi;
		int unsigned tries;
		bit [COORD_W-1:0] xc;
		bit [COORD_W-1:0] yc;
		bit found;
		set_size(w, h);
		ew = (w > MAX_W) ? MAX_W : w;
		eh = (h > MAX_H) ? MAX_H : h;
		ww = (ew < 8) ? ew : 8;
		wh = (eh < 8) ? eh : 8;
		if (ww == 0) ww = 1;
		if (wh == 0) wh = 1;
		case ($urandom_range(0, 2))
			0: begin
				ox = 0;
				oy = 0;
			end
			1: begin
				ox = (ew > ww) ? ew - ww : 0;
				oy = (eh > wh) ? eh - wh : 0;
			end
			default: begin
				ox = $urandom_range(0, (ew > ww) ? ew - ww : 0);
				oy = $urandom_range(0, (eh > wh) ? eh - wh : 0);
			end
		endcase
		for (int y = oy; y < oy + wh; y++) begin
			for (int x = ox; x < ox + ww; x++) begin
				write_px(8'(x), 8'(y), pick_pixel());
			end
		end
		repeat (n_items) begin
			found = 1'b0;
			if ($urandom_range(0, 9) >= 4) begin
				tries = 0;
				while (!found && tries < 20) begin
					if ($urandom_range(0, 7) == 0) begin
						xc = 16'($urandom);
						yc = 16'($urandom);
					end else begin
						xi = ((ox == 0) ? 0 : ox - 1) + $urandom_range(0, ww + 1);
						yi = ((oy == 0) ? 0 : oy - 1) + $urandom_range(0, wh + 1);
						if (xi > 255) xi = 255;
						if (yi > 255) yi = 255;
						xc = {xi[7:0], pick_frac()};
						yc = {yi[7:0], pick_frac()};
					end
					found = sb.can_sample(xc, yc);
					tries++;
				end
			end
			if (found) begin
				sample_at(xc, yc);
			end else if ($urandom_range(0, 5) == 0) begin
				send_item(make_item(CMD_WRITE, 16'($urandom), 16'($urandom), pick_pixel()));
			end else begin
				xi = ox + $urandom_range(0, ww);
				yi = oy + $urandom_range(0, wh);
				if (xi > 255) xi = 255;
				if (yi > 255) yi = 255;
				write_px(xi[7:0], yi[7:0], pick_pixel());
			end
		end
		settle();
	endtask

	int unsigned widths [NUM_PHASES] = '{4, 1, 256, 1, 256, 13, 0, 300, 2};
	int unsigned heights [NUM_PHASES] = '{3, 1, 256, 256, 1, 7, 300, 5, 2};

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ACTIVE_WIDTH;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed transactions at the reset size: the top-left and bottom-right corners of the frame.
		write_px(0, 0, 32'h0000_0000);
		write_px(1, 0, 32'hFFFF_FFFF);
		write_px(0, 1, 32'h8040_2010);
		write_px(1, 1, 32'h01FF_7F00);
		write_px(254, 254, 32'h5A5A_A5A5);
		write_px(255, 254, 32'h0F0F_F0F0);
		write_px(254, 255, 32'hC3C3_3C3C);
		write_px(255, 255, 32'hFFFF_FFFF);
		sample_at(16'h0000, 16'h0000);
		sample_at(16'h0080, 16'h0080);
		sample_at(16'h00FF, 16'h00FF);
		sample_at(16'h00FF, 16'h0000);
		sample_at(16'h0000, 16'h00FF);
		sample_at(16'h0001, 16'h0001);
		sample_at(16'hFE80, 16'hFE40);
		// Samples past the right and bottom edges blend in the border pixel.
		sample_at(16'hFFFF, 16'hFFFF);
		sample_at(16'hFF00, 16'hFE80);
		sample_at(16'hFE00, 16'hFFFF);
		settle();

		for (int i = 0; i < NUM_PHASES; i++) begin
			run_phase(widths[i], heights[i], PHASE_ITEMS);
		end

		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/brs_pkg.sv
hdl/brs_ram.sv
hdl/brs_blend.sv
hdl/bilinear_rgba_sampler.sv
tb/testbench.sv
